// ----- src/bebm_pkg.sv -----
// ----------------------------------------------------------------------------
// bebm_pkg
// Shared types and constants of the binary erosion, block AND and start code
// unit.
// ----------------------------------------------------------------------------
package bebm_pkg;

  localparam int unsigned BEBM_MAX_DIM   = 1024;
  localparam int unsigned BEBM_BLOCK     = 4;
  localparam int unsigned CFG_W          = 11;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_RESET      = 1024;
  localparam int unsigned NUM_TAPS       = 2;
  localparam int unsigned CODE_W         = 2;
  localparam int unsigned SETTLE_CYCLES  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_COLS = 1'b0,
    REG_MAP_ROWS = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_CELL  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [CODE_W-1:0] {
    SC_BLOCKED  = 2'd0,
    SC_BORDER   = 2'd1,
    SC_INTERIOR = 2'd2
  } start_code_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic use_tap;
  } cell_ctl_t;

endpackage

// ----- src/bebm_cell.sv -----
// ----------------------------------------------------------------------------
// bebm_cell
// One tap of the vertical erosion window: holds the horizontal AND of one row
// above, hands it to the next cell on shift and folds it into the running AND.
// ----------------------------------------------------------------------------
module bebm_cell
  import bebm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      d_in,
  input  logic      and_in,
  output logic      q,
  output logic      and_out
);

  logic q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= 1'b0;
    end else if (ctl.clear) begin
      q_r <= 1'b0;
    end else if (ctl.shift) begin
      q_r <= d_in;
    end
  end

  assign q       = q_r;
  assign and_out = and_in & (q_r | ~ctl.use_tap);

endmodule

// ----- src/binary_erosion_block_and_map_unit.sv -----
// ----------------------------------------------------------------------------
// binary_erosion_block_and_map_unit
// Streaming 3x3 erosion, block AND and start codes for a walkability map.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one map cell per item, column by column,
// rows inside a column; in_op marks flush items that drain the last column.
// A map takes cols*rows cell items followed by rows+1 flush items.
// Result channel (out_valid/out_stall): exactly one result per input item,
// in order, each through the work stage and then the output register. The
// eroded cell trails the stream by one column plus one cell. Throughput is
// one item per cycle while the input is not stalled; the line buffer and
// block memory are read when an item is accepted and written when it moves
// to the output register. A stalled output holds its result; one further
// item waits in the work stage and the input stalls behind it.
// Configuration (cfg_valid/cfg_ready): a write restarts the frame; the input
// and cfg_ready stay stalled while the effective size is formed.
// Reset sets both dimensions to 1024 and starts a new frame; the memories
// need no clearing pass.
// ----------------------------------------------------------------------------
module binary_erosion_block_and_map_unit
  import bebm_pkg::*;
#(
  parameter int unsigned MAX_DIM    = BEBM_MAX_DIM,
  parameter int unsigned BLOCK_SIZE = BEBM_BLOCK
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic                 in_raw_walkable,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_eroded_valid,
  output logic                 out_eroded_bit,
  output logic [CODE_W-1:0]    out_start_code,
  output logic                 out_block_valid,
  output logic                 out_block_bit,
  output logic                 out_frame_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned YM_W   = $clog2(BLOCK_SIZE);
  localparam int unsigned NBLK   = (MAX_DIM + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int unsigned BI_W   = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int unsigned CW     = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam int unsigned RCP_SH = DIM_W + YM_W;
  localparam int unsigned PW     = DIM_W + RCP_SH;
  localparam longint unsigned RCP_M =
    ((64'd1 << RCP_SH) + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int unsigned RST_CLAMP = (CFG_RESET > MAX_DIM) ? MAX_DIM :
                                      ((CFG_RESET < BLOCK_SIZE) ? BLOCK_SIZE : CFG_RESET);
  localparam int unsigned RST_Q   = RST_CLAMP / BLOCK_SIZE;
  localparam int unsigned RST_EFF = (RST_Q == 0) ? BLOCK_SIZE : RST_Q * BLOCK_SIZE;
  localparam int unsigned ST_W    = $clog2(SETTLE_CYCLES + 1);

  typedef enum logic [1:0] {
    K_IGN,
    K_CELL,
    K_FLUSH,
    K_END
  } kind_t;

  // configuration and effective size
  logic [DIM_W-1:0] cols_clamp_r, rows_clamp_r;
  logic [DIM_W-1:0] cols_q_r, rows_q_r;
  logic [DIM_W-1:0] cols_eff_r, rows_eff_r;
  logic [ST_W-1:0]  settle_r;
  logic             cfg_we;
  logic [CW-1:0]    cfg_ext;
  logic [DIM_W-1:0] cfg_clamp;
  logic [PW-1:0]    cols_prod, rows_prod;

  // stream position
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [AW-1:0]    row_r, row_nxt;
  logic [DIM_W-1:0] flush_r, flush_nxt;
  logic [YM_W-1:0]  xm_r, xm_nxt, ym_r, ym_nxt;
  logic [BI_W-1:0]  bi_r, bi_nxt;

  // accept decode
  logic             in_acc;
  kind_t            kind_nxt;
  logic [DIM_W-1:0] y_cur;
  logic             x_ge1, x_ge2, x_last, y_zero, y_last, border;
  logic [NUM_TAPS-1:0] use_cur;
  logic [AW-1:0]    rd_addr;

  // work stage
  logic                a_valid_r;
  kind_t               a_kind_r;
  logic                a_raw_r, a_xge1_r, a_xge2_r, a_border_r, a_yzero_r, a_ylast_r;
  logic [NUM_TAPS-1:0] a_use_r;
  logic                a_ymfirst_r, a_ymlast_r, a_xmfirst_r, a_blkdone_r;
  logic [AW-1:0]       a_addr_r;
  logic [BI_W-1:0]     a_bi_r;
  logic                a_adv;

  // memories
  logic [1:0]      lb_mem [MAX_DIM];
  logic [1:0]      lb_rd_r;
  logic            blk_mem [NBLK];
  logic            blk_rd_r;
  logic            lb_we, blk_we;
  logic [1:0]      lb_wd;
  logic            blk_wd;

  // vertical window and results
  logic                h0, oc, vert_en;
  logic                held_bit_r, held_valid_r;
  logic                col_and_r, col_and_nxt;
  logic [NUM_TAPS-1:0] tap_q, tap_and;
  cell_ctl_t           tap_ctl [NUM_TAPS];
  logic                er_valid, er_bit, blk_val;
  logic [CODE_W-1:0]   code;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  assign cfg_ready = (settle_r == '0);
  assign cfg_we    = cfg_valid & cfg_ready;
  assign cfg_ext   = CW'(cfg_data);

  always_comb begin
    if (cfg_ext < CW'(BLOCK_SIZE)) begin
      cfg_clamp = DIM_W'(BLOCK_SIZE);
    end else if (cfg_ext > CW'(MAX_DIM)) begin
      cfg_clamp = DIM_W'(MAX_DIM);
    end else begin
      cfg_clamp = DIM_W'(cfg_ext);
    end
  end

  assign cols_prod = PW'(cols_clamp_r) * PW'(RCP_M);
  assign rows_prod = PW'(rows_clamp_r) * PW'(RCP_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_clamp_r <= DIM_W'(RST_CLAMP);
      rows_clamp_r <= DIM_W'(RST_CLAMP);
      cols_q_r     <= DIM_W'(RST_Q);
      rows_q_r     <= DIM_W'(RST_Q);
      cols_eff_r   <= DIM_W'(RST_EFF);
      rows_eff_r   <= DIM_W'(RST_EFF);
      settle_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_MAP_COLS: cols_clamp_r <= cfg_clamp;
          REG_MAP_ROWS: rows_clamp_r <= cfg_clamp;
          default: ;
        endcase
        settle_r <= ST_W'(SETTLE_CYCLES);
      end else if (settle_r != '0) begin
        settle_r <= settle_r - ST_W'(1);
      end
      cols_q_r   <= cols_prod[PW-1:RCP_SH];
      rows_q_r   <= rows_prod[PW-1:RCP_SH];
      cols_eff_r <= (cols_q_r == '0) ? DIM_W'(BLOCK_SIZE)
                                     : DIM_W'(cols_q_r * DIM_W'(BLOCK_SIZE));
      rows_eff_r <= (rows_q_r == '0) ? DIM_W'(BLOCK_SIZE)
                                     : DIM_W'(rows_q_r * DIM_W'(BLOCK_SIZE));
    end
  end

  // --------------------------------------------------------------------------
  // accept and stream position
  // --------------------------------------------------------------------------
  assign a_adv    = a_valid_r & (~out_valid | ~out_stall);
  assign in_stall = (a_valid_r & ~a_adv) | (settle_r != '0);
  assign in_acc   = in_valid & ~in_stall;

  assign x_ge1   = (col_r != '0);
  assign x_ge2   = (col_r > DIM_W'(1));
  assign x_last  = (col_r == cols_eff_r - DIM_W'(1));
  assign y_cur   = (op_t'(in_op) == OP_CELL) ? DIM_W'(row_r) : flush_r;
  assign y_zero  = (y_cur == '0);
  assign y_last  = (DIM_W'(y_cur + DIM_W'(1)) == rows_eff_r);
  assign border  = ~x_ge1 | x_last | y_zero | y_last;
  assign rd_addr = y_cur[AW-1:0];

  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      use_cur[i] = (y_cur > DIM_W'(i));
    end
  end

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    flush_nxt = flush_r;
    xm_nxt    = xm_r;
    ym_nxt    = ym_r;
    bi_nxt    = bi_r;
    kind_nxt  = K_IGN;
    if (in_acc) begin
      unique case (op_t'(in_op))
        OP_CELL: begin
          if (col_r < cols_eff_r) begin
            kind_nxt = K_CELL;
            if (y_last) begin
              row_nxt = '0;
              col_nxt = col_r + DIM_W'(1);
              ym_nxt  = '0;
              bi_nxt  = '0;
              xm_nxt  = (xm_r == YM_W'(BLOCK_SIZE - 1)) ? '0 : xm_r + YM_W'(1);
            end else begin
              row_nxt = row_r + AW'(1);
              if (ym_r == YM_W'(BLOCK_SIZE - 1)) begin
                ym_nxt = '0;
                bi_nxt = bi_r + BI_W'(1);
              end else begin
                ym_nxt = ym_r + YM_W'(1);
              end
            end
          end
        end
        OP_FLUSH: begin
          if (col_r >= cols_eff_r) begin
            if (flush_r < rows_eff_r) begin
              kind_nxt  = K_FLUSH;
              flush_nxt = flush_r + DIM_W'(1);
            end else begin
              kind_nxt  = K_END;
              col_nxt   = '0;
              row_nxt   = '0;
              flush_nxt = '0;
              xm_nxt    = '0;
              ym_nxt    = '0;
              bi_nxt    = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      col_r   <= '0;
      row_r   <= '0;
      flush_r <= '0;
      xm_r    <= '0;
      ym_r    <= '0;
      bi_r    <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      flush_r <= flush_nxt;
      xm_r    <= xm_nxt;
      ym_r    <= ym_nxt;
      bi_r    <= bi_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // work stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
    end else if (a_adv) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_kind_r    <= kind_nxt;
      a_raw_r     <= in_raw_walkable;
      a_xge1_r    <= x_ge1;
      a_xge2_r    <= x_ge2;
      a_border_r  <= border;
      a_yzero_r   <= y_zero;
      a_ylast_r   <= y_last;
      a_use_r     <= use_cur;
      a_ymfirst_r <= (ym_r == '0);
      a_ymlast_r  <= (ym_r == YM_W'(BLOCK_SIZE - 1));
      a_xmfirst_r <= (xm_r == '0);
      a_blkdone_r <= (ym_r == YM_W'(BLOCK_SIZE - 1)) & (xm_r == YM_W'(BLOCK_SIZE - 1));
      a_addr_r    <= rd_addr;
      a_bi_r      <= bi_r;
    end
  end

  // --------------------------------------------------------------------------
  // line buffer {older, prev} and block accumulator
  // --------------------------------------------------------------------------
  assign lb_we  = a_adv & (a_kind_r == K_CELL);
  assign lb_wd  = {lb_rd_r[0], a_raw_r};
  assign blk_we = a_adv & (a_kind_r == K_CELL) & a_ymlast_r;
  assign blk_wd = blk_val;

  always_ff @(posedge clk) begin
    if (lb_we) begin
      lb_mem[a_addr_r] <= lb_wd;
    end
    if (in_acc) begin
      lb_rd_r <= (lb_we && a_addr_r == rd_addr) ? lb_wd : lb_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[a_bi_r] <= blk_wd;
    end
    if (in_acc) begin
      blk_rd_r <= (blk_we && a_bi_r == bi_r) ? blk_wd : blk_mem[bi_r];
    end
  end

  // --------------------------------------------------------------------------
  // vertical window
  // --------------------------------------------------------------------------
  assign oc      = a_xge2_r ? lb_rd_r[1] : 1'b1;
  assign h0      = (a_kind_r == K_CELL) ? (oc & lb_rd_r[0] & a_raw_r)
                                        : (lb_rd_r[1] & lb_rd_r[0]);
  assign vert_en = ((a_kind_r == K_CELL) & a_xge1_r) | (a_kind_r == K_FLUSH);

  for (genvar g = 0; g < NUM_TAPS; g++) begin : g_tap
    logic d_in, and_in;
    if (g == 0) begin : g_head
      assign d_in   = h0;
      assign and_in = h0;
    end else begin : g_link
      assign d_in   = tap_q[g-1];
      assign and_in = tap_and[g-1];
    end
    assign tap_ctl[g].shift   = a_adv & vert_en;
    assign tap_ctl[g].clear   = (a_adv & (a_kind_r == K_END)) | cfg_we;
    assign tap_ctl[g].use_tap = a_use_r[g];
    bebm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (tap_ctl[g]),
      .d_in    (d_in),
      .and_in  (and_in),
      .q       (tap_q[g]),
      .and_out (tap_and[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      held_bit_r   <= 1'b0;
      held_valid_r <= 1'b0;
    end else if (a_adv) begin
      if (a_kind_r == K_END) begin
        held_bit_r   <= 1'b0;
        held_valid_r <= 1'b0;
      end else if (vert_en && a_ylast_r) begin
        held_bit_r   <= h0 & tap_q[0];
        held_valid_r <= 1'b1;
      end else if (vert_en && a_yzero_r) begin
        held_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    er_valid = 1'b0;
    er_bit   = 1'b0;
    if (a_kind_r == K_END) begin
      er_valid = held_valid_r;
      er_bit   = held_valid_r & held_bit_r;
    end else if (vert_en) begin
      if (a_yzero_r) begin
        er_valid = held_valid_r;
        er_bit   = held_valid_r & held_bit_r;
      end else begin
        er_valid = 1'b1;
        er_bit   = tap_and[NUM_TAPS-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // block AND and start code
  // --------------------------------------------------------------------------
  assign col_and_nxt = a_ymfirst_r ? a_raw_r : (col_and_r & a_raw_r);
  assign blk_val     = a_xmfirst_r ? col_and_nxt : (blk_rd_r & col_and_nxt);

  always_ff @(posedge clk) begin
    if (a_adv && a_kind_r == K_CELL) begin
      col_and_r <= col_and_nxt;
    end
  end

  always_comb begin
    code = SC_BLOCKED;
    if (a_kind_r == K_CELL && a_raw_r) begin
      code = a_border_r ? SC_BORDER : SC_INTERIOR;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (a_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_eroded_valid <= er_valid;
      out_eroded_bit   <= er_bit;
      out_start_code   <= code;
      out_block_valid  <= (a_kind_r == K_CELL) & a_blkdone_r;
      out_block_bit    <= (a_kind_r == K_CELL) & a_blkdone_r & blk_val;
      out_frame_done   <= (a_kind_r == K_END);
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    DIM_W'(row_r) < rows_eff_r)
    else $error("row counter beyond map height");

  a_end_has_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && a_kind_r == K_END) |-> held_valid_r)
    else $error("frame end without pending bottom cell");

  a_work_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !a_adv) |=> (a_valid_r && $stable(a_kind_r) && $stable(a_addr_r)))
    else $error("work stage lost a stalled item");

endmodule

// ----- verif/bebm_erosion_checker.sv -----
// ----------------------------------------------------------------------------
// bebm_erosion_checker
// Watches the input, result and register channels of the erosion unit, keeps
// its own model of the line buffers, block accumulators and stream position,
// and compares every accepted result, field by field, with the oldest
// predicted one. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module bebm_erosion_checker
  import bebm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_op,
  input  logic                 in_raw_walkable,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_eroded_valid,
  input  logic                 out_eroded_bit,
  input  logic [CODE_W-1:0]    out_start_code,
  input  logic                 out_block_valid,
  input  logic                 out_block_bit,
  input  logic                 out_frame_done,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 100;
  localparam int BLOCK_ROWS  = BEBM_MAX_DIM / BEBM_BLOCK;

  typedef struct packed {
    logic        eroded_valid;
    logic        eroded_bit;
    start_code_t start_code;
    logic        block_valid;
    logic        block_bit;
    logic        frame_done;
  } map_result_t;

  logic [CFG_W-1:0] cols_reg;
  logic [CFG_W-1:0] rows_reg;
  logic             prev_col  [BEBM_MAX_DIM];
  logic             older_col [BEBM_MAX_DIM];
  logic             block_and [BLOCK_ROWS];
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      flush_pos;
  logic             hand_above;
  logic             hand_above2;
  logic             held_bit;
  logic             held_valid;
  int               results_seen;
  map_result_t      expected_results [$];

  function automatic int unsigned map_extent(logic [CFG_W-1:0] v);
    int unsigned d;
    d = v;
    if (d < BEBM_BLOCK) d = BEBM_BLOCK;
    if (d > BEBM_MAX_DIM) d = BEBM_MAX_DIM;
    return d - d % BEBM_BLOCK;
  endfunction

  function automatic void restart_frame();
    col_pos     = 0;
    row_pos     = 0;
    flush_pos   = 0;
    hand_above  = 1'b0;
    hand_above2 = 1'b0;
    held_bit    = 1'b0;
    held_valid  = 1'b0;
  endfunction

  function automatic void reset_model();
    cols_reg = CFG_W'(CFG_RESET);
    rows_reg = CFG_W'(CFG_RESET);
    for (int i = 0; i < BEBM_MAX_DIM; i++) begin
      prev_col[i]  = 1'b1;
      older_col[i] = 1'b1;
    end
    for (int i = 0; i < BLOCK_ROWS; i++) block_and[i] = 1'b1;
    restart_frame();
    expected_results.delete();
  endfunction

  // vertical AND over up to three horizontal ANDs; bottom row is held for the next column
  function automatic void fold_rows(int unsigned y, logic h0, int unsigned rows,
                                    inout map_result_t r);
    if (y == 0) begin
      if (held_valid) begin
        r.eroded_valid = 1'b1;
        r.eroded_bit   = held_bit;
        held_valid     = 1'b0;
      end
    end else begin
      r.eroded_valid = 1'b1;
      r.eroded_bit   = h0 & hand_above & ((y >= 2) ? hand_above2 : 1'b1);
    end
    if (y + 1 == rows) begin
      held_bit   = h0 & hand_above;
      held_valid = 1'b1;
    end
    hand_above2 = hand_above;
    hand_above  = h0;
  endfunction

  function automatic map_result_t predict_erosion(op_t op, logic raw);
    map_result_t r;
    int unsigned cols;
    int unsigned rows;
    int unsigned x;
    int unsigned y;
    int unsigned bi;
    logic        acc;
    logic        oc;
    r    = '0;
    cols = map_extent(cols_reg);
    rows = map_extent(rows_reg);
    if (op == OP_CELL) begin
      x = col_pos;
      y = row_pos;
      if (x >= cols || y >= rows) return r;
      if (raw)
        r.start_code = (x == 0 || x == cols - 1 || y == 0 || y == rows - 1) ?
                       SC_BORDER : SC_INTERIOR;
      bi  = y / BEBM_BLOCK;
      acc = (x % BEBM_BLOCK == 0 && y % BEBM_BLOCK == 0) ? raw : (block_and[bi] & raw);
      block_and[bi] = acc;
      if (x % BEBM_BLOCK == BEBM_BLOCK - 1 && y % BEBM_BLOCK == BEBM_BLOCK - 1) begin
        r.block_valid = 1'b1;
        r.block_bit   = acc;
      end
      if (x >= 1) begin
        oc = (x >= 2) ? older_col[y] : 1'b1;
        fold_rows(y, oc & prev_col[y] & raw, rows, r);
      end
      older_col[y] = prev_col[y];
      prev_col[y]  = raw;
      if (y + 1 >= rows) begin
        row_pos = 0;
        col_pos = x + 1;
      end else begin
        row_pos = y + 1;
      end
    end else begin
      if (col_pos < cols) return r;
      if (flush_pos < rows) begin
        fold_rows(flush_pos, older_col[flush_pos] & prev_col[flush_pos], rows, r);
        flush_pos++;
      end else begin
        if (held_valid) begin
          r.eroded_valid = 1'b1;
          r.eroded_bit   = held_bit;
        end
        r.frame_done = 1'b1;
        restart_frame();
      end
    end
    return r;
  endfunction

  task automatic report_error(string what, int got, int want);
    if (fail_count < MAX_REPORTS)
      $display("ERROR result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    map_result_t want;
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAP_COLS: cols_reg = cfg_data;
          REG_MAP_ROWS: rows_reg = cfg_data;
          default: ;
        endcase
        restart_frame();
      end
      if (in_valid && !in_stall)
        expected_results.insert(expected_results.size(),
                                predict_erosion(op_t'(in_op), in_raw_walkable));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_error("unexpected result", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_eroded_valid !== want.eroded_valid)
            report_error("eroded_valid", out_eroded_valid, want.eroded_valid);
          if (out_eroded_bit !== want.eroded_bit)
            report_error("eroded_bit", out_eroded_bit, want.eroded_bit);
          if (out_start_code !== want.start_code)
            report_error("start_code", out_start_code, want.start_code);
          if (out_block_valid !== want.block_valid)
            report_error("block_valid", out_block_valid, want.block_valid);
          if (out_block_bit !== want.block_bit)
            report_error("block_bit", out_block_bit, want.block_bit);
          if (out_frame_done !== want.frame_done)
            report_error("frame_done", out_frame_done, want.frame_done);
        end
        results_seen++;
      end
    end
    results_due = expected_results.size();
  end

endmodule

// ----- verif/tb_binary_erosion_block_and_map_unit.sv -----
// ----------------------------------------------------------------------------
// tb_binary_erosion_block_and_map_unit
// Drives walkability maps of many sizes through the erosion unit: a short
// directed map, a small map under a long result hold-off, partial maps at the
// largest extents, then random maps with random content, stray flush and cell
// items, abandoned maps and random idling on both channels. The checker beside
// the unit compares every result; the verdict comes from its failure count.
// ----------------------------------------------------------------------------
module tb_binary_erosion_block_and_map_unit
  import bebm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF        = 2;
  localparam int RESET_CYCLES    = 7;
  localparam int CYCLE_LIMIT     = 500_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEM_TARGET     = 1250;
  localparam int ABANDON_MAX     = 120;
  localparam int SETTLE_CYCLES_T = 8;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic                 in_op           = 1'b0;
  logic                 in_raw_walkable = 1'b0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic                 out_eroded_valid;
  logic                 out_eroded_bit;
  logic [CODE_W-1:0]    out_start_code;
  logic                 out_block_valid;
  logic                 out_block_bit;
  logic                 out_frame_done;
  logic                 cfg_valid       = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [CFG_W-1:0]     cfg_data        = '0;

  int fail_count;
  int results_due;
  int cycle_count     = 0;
  int map_items       = 0;
  int hold_off_asked  = 0;
  int hold_off_served = 0;
  bit tx_idle_en      = 1'b0;
  bit rx_idle_en      = 1'b0;

  binary_erosion_block_and_map_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_raw_walkable  (in_raw_walkable),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_eroded_valid (out_eroded_valid),
    .out_eroded_bit   (out_eroded_bit),
    .out_start_code   (out_start_code),
    .out_block_valid  (out_block_valid),
    .out_block_bit    (out_block_bit),
    .out_frame_done   (out_frame_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  bebm_erosion_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_raw_walkable  (in_raw_walkable),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_eroded_valid (out_eroded_valid),
    .out_eroded_bit   (out_eroded_bit),
    .out_start_code   (out_start_code),
    .out_block_valid  (out_block_valid),
    .out_block_bit    (out_block_bit),
    .out_frame_done   (out_frame_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .results_due      (results_due)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int map_extent(int v);
    int d;
    d = (v < BEBM_BLOCK) ? BEBM_BLOCK : ((v > BEBM_MAX_DIM) ? BEBM_MAX_DIM : v);
    return d - d % BEBM_BLOCK;
  endfunction

  function automatic int pick_dim_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 3);
    if (r == 1) return 4 * $urandom_range(1, 4) + $urandom_range(1, 3);
    return 4 * $urandom_range(1, 4);
  endfunction

  // hold the result side: long hold-off on request, else random stalls
  always begin : rx_pacing
    @(negedge clk);
    if (hold_off_asked != hold_off_served) begin
      out_stall <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(negedge clk);
      hold_off_served++;
      out_stall <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      repeat (idle_len()) @(negedge clk);
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(op_t op, logic raw);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_raw_walkable <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_map_size(int cols_val, int rows_val);
    drain();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_MAP_COLS, CFG_W'(cols_val));
      write_reg(REG_MAP_ROWS, CFG_W'(rows_val));
    end else begin
      write_reg(REG_MAP_ROWS, CFG_W'(rows_val));
      write_reg(REG_MAP_COLS, CFG_W'(cols_val));
    end
  endtask

  task automatic run_map(int cols, int rows, int density, bit abandon);
    int n_cells;
    int cap;
    cap     = (cols * rows - 1 < ABANDON_MAX) ? cols * rows - 1 : ABANDON_MAX;
    n_cells = abandon ? $urandom_range(1, cap) : cols * rows;
    for (int i = 0; i < n_cells; i++) begin
      if ($urandom_range(0, 49) == 0) send_item(OP_FLUSH, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 299) == 0) drain();
      send_item(OP_CELL, $urandom_range(0, 99) < density);
      map_items++;
    end
    if (abandon) return;
    for (int f = 0; f <= rows; f++) begin
      if (f < rows && $urandom_range(0, 29) == 0)
        send_item(OP_CELL, 1'($urandom_range(0, 1)));
      send_item(OP_FLUSH, 1'($urandom_range(0, 1)));
      map_items++;
    end
  endtask

  initial begin : stimulus
    int cols_val;
    int rows_val;
    int n_maps;
    int density;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed 4x4 map: stray flush, one blocked cell, stray cell, drain
    write_reg(REG_MAP_COLS, CFG_W'(4));
    write_reg(REG_MAP_ROWS, CFG_W'(4));
    send_item(OP_FLUSH, 1'b1);
    for (int x = 0; x < 4; x++)
      for (int y = 0; y < 4; y++)
        send_item(OP_CELL, !(x == 1 && y == 2));
    send_item(OP_CELL, 1'b1);
    repeat (5) send_item(OP_FLUSH, 1'b0);

    // long result hold-off while the sender keeps offering a full map
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    set_map_size(9, 10);
    hold_off_asked++;
    run_map(8, 8, 97, 1'b0);

    // largest extents, partial maps
    set_map_size(2047, 5);
    run_map(BEBM_MAX_DIM, BEBM_BLOCK, 97, 1'b1);
    set_map_size(0, 1027);
    run_map(BEBM_BLOCK, BEBM_MAX_DIM, 99, 1'b1);

    while (map_items < ITEM_TARGET) begin
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      cols_val   = pick_dim_value();
      rows_val   = pick_dim_value();
      set_map_size(cols_val, rows_val);
      n_maps = $urandom_range(1, 3);
      for (int m = 0; m < n_maps && map_items < ITEM_TARGET; m++) begin
        case ($urandom_range(0, 3))
          0:       density = 40;
          1:       density = 90;
          2:       density = 97;
          default: density = 100;
        endcase
        run_map(map_extent(cols_val), map_extent(rows_val), density,
                m == n_maps - 1 && $urandom_range(0, 5) == 0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES_T) @(negedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/bebm_pkg.sv
src/bebm_cell.sv
src/binary_erosion_block_and_map_unit.sv
verif/bebm_erosion_checker.sv
verif/tb_binary_erosion_block_and_map_unit.sv
